/* sv/elx_pkg.sv */
package elx_pkg;

  localparam int unsigned MaxIdentCharsDef = 8;
  localparam int unsigned NumberBitsDef    = 31;

  localparam int unsigned NumValW   = 31;
  localparam int unsigned IdentW    = 64;
  localparam int unsigned IdentLenW = 4;

  // result queue, room for the two results one beat may cause
  localparam int unsigned QDepth = 4;

  typedef enum logic [0:0] {
    IN_CHAR = 1'b0,
    IN_END  = 1'b1
  } in_mode_e;

  typedef enum logic [3:0] {
    TK_NUMBER = 4'd0,
    TK_IDENT  = 4'd1,
    TK_PLUS   = 4'd2,
    TK_MINUS  = 4'd3,
    TK_MUL    = 4'd4,
    TK_DIV    = 4'd5,
    TK_EQUAL  = 4'd6,
    TK_OPEN   = 4'd7,
    TK_CLOSE  = 4'd8,
    TK_SEMI   = 4'd9,
    TK_ERROR  = 4'd10
  } token_kind_e;

  typedef struct packed {
    in_mode_e    mode;
    logic [7:0]  char_code;
  } lex_in_t;

  typedef struct packed {
    token_kind_e           token_kind;
    logic [NumValW-1:0]    number_value;
    logic                  number_saturated;
    logic [IdentW-1:0]     ident_chars;
    logic [IdentLenW-1:0]  ident_length;
    logic                  ident_truncated;
    logic [7:0]            bad_char;
    logic                  last_of_run;
  } lex_out_t;

  // results of one accepted beat, first is taken before second
  typedef struct packed {
    logic [1:0] count;
    lex_out_t   first;
    lex_out_t   second;
  } elx_pair_t;

endpackage

/* sv/elx_scan.sv */
module elx_scan import elx_pkg::*; #(
  parameter int unsigned MaxIdentChars = MaxIdentCharsDef,
  parameter int unsigned NumberBits    = NumberBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  lex_in_t   in_i,
  output elx_pair_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_NUM   = 2'd1,
    ST_IDENT = 2'd2
  } lex_state_e;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7a;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChEqual = 8'h3d;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChSemi  = 8'h3b;

  localparam int unsigned ProdW = NumberBits + 4;
  localparam logic [NumberBits-1:0] NumMax = {NumberBits{1'b1}};

  lex_state_e              st_q, st_d;
  logic [NumberBits-1:0]   acc_q, acc_d;
  logic                    num_ovf_q, num_ovf_d;
  logic [IdentW-1:0]       id_buf_q, id_buf_d;
  logic [IdentLenW-1:0]    id_cnt_q, id_cnt_d;
  logic                    id_ovf_q, id_ovf_d;

  logic [7:0]  ch;
  logic        is_end, is_digit, is_alpha, is_space, is_ident_ch;
  logic        in_num, in_ident, extend, flush_emit, char_emit;
  logic [3:0]  digit;
  logic [ProdW-1:0] prod;
  logic        prod_sat;
  logic [IdentW-1:0] id_app_buf;
  logic        id_room;
  logic [NumberBits+NumValW-1:0] acc_wide;
  token_kind_e op_kind;
  lex_out_t    pend_tok, char_tok;

  assign ch          = in_i.char_code;
  assign is_end      = (in_i.mode == IN_END);
  assign is_digit    = (ch >= ChZero) && (ch <= ChNine);
  assign is_alpha    = ((ch >= ChUpA) && (ch <= ChUpZ)) || ((ch >= ChLoA) && (ch <= ChLoZ));
  assign is_space    = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
  assign is_ident_ch = is_alpha || is_digit || (ch == ChUnder);
  assign digit       = 4'(ch - ChZero);

  assign in_num   = (st_q == ST_NUM);
  assign in_ident = (st_q == ST_IDENT);

  // the byte continues the pending token
  assign extend     = !is_end && ((in_num && is_digit) || (in_ident && is_ident_ch));
  assign flush_emit = !extend && (in_num || in_ident);
  assign char_emit  = !is_end && !extend && !is_space && !is_digit && !is_alpha;

  // acc*10 + d, clamped; acc never exceeds NumMax so four extra bits suffice
  assign prod     = (ProdW'(acc_q) << 3) + (ProdW'(acc_q) << 1) + ProdW'(digit);
  assign prod_sat = prod > ProdW'(NumMax);

  assign id_room = id_cnt_q < IdentLenW'(MaxIdentChars);

  always_comb begin
    id_app_buf = id_buf_q;
    for (int i = 0; i < IdentW / 8; i++) begin
      if (id_room && (id_cnt_q == IdentLenW'(i))) begin
        id_app_buf[i*8 +: 8] = ch;
      end
    end
  end

  always_comb begin
    unique case (ch)
      ChPlus:  op_kind = TK_PLUS;
      ChMinus: op_kind = TK_MINUS;
      ChStar:  op_kind = TK_MUL;
      ChSlash: op_kind = TK_DIV;
      ChEqual: op_kind = TK_EQUAL;
      ChOpen:  op_kind = TK_OPEN;
      ChClose: op_kind = TK_CLOSE;
      ChSemi:  op_kind = TK_SEMI;
      default: op_kind = TK_ERROR;
    endcase
  end

  assign acc_wide = {{NumValW{1'b0}}, acc_q};

  always_comb begin
    pend_tok = '0;
    if (in_num) begin
      pend_tok.token_kind       = TK_NUMBER;
      pend_tok.number_value     = acc_wide[NumValW-1:0];
      pend_tok.number_saturated = num_ovf_q;
    end else begin
      pend_tok.token_kind      = TK_IDENT;
      pend_tok.ident_chars     = id_buf_q;
      pend_tok.ident_length    = id_cnt_q;
      pend_tok.ident_truncated = id_ovf_q;
    end

    char_tok             = '0;
    char_tok.token_kind  = op_kind;
    char_tok.bad_char    = (op_kind == TK_ERROR) ? ch : 8'h00;
    char_tok.last_of_run = 1'b1;
  end

  always_comb begin
    res_o        = '0;
    res_o.count  = 2'(flush_emit) + 2'(char_emit);
    res_o.second = char_tok;
    if (flush_emit) begin
      res_o.first             = pend_tok;
      res_o.first.last_of_run = !char_emit;
    end else begin
      res_o.first = char_tok;
    end
  end

  always_comb begin
    st_d      = st_q;
    acc_d     = acc_q;
    num_ovf_d = num_ovf_q;
    id_buf_d  = id_buf_q;
    id_cnt_d  = id_cnt_q;
    id_ovf_d  = id_ovf_q;
    if (take_i) begin
      if (extend && in_num) begin
        acc_d     = prod_sat ? NumMax : prod[NumberBits-1:0];
        num_ovf_d = num_ovf_q | prod_sat;
      end else if (extend) begin
        id_buf_d = id_app_buf;
        id_cnt_d = id_room ? id_cnt_q + 1'b1 : id_cnt_q;
        id_ovf_d = id_ovf_q | !id_room;
      end else begin
        st_d      = ST_IDLE;
        acc_d     = '0;
        num_ovf_d = 1'b0;
        id_buf_d  = '0;
        id_cnt_d  = '0;
        id_ovf_d  = 1'b0;
        if (!is_end && is_digit) begin
          st_d  = ST_NUM;
          acc_d = NumberBits'(digit);
        end else if (!is_end && is_alpha) begin
          st_d            = ST_IDENT;
          id_buf_d[7:0]   = ch;
          id_cnt_d        = IdentLenW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      acc_q     <= '0;
      num_ovf_q <= 1'b0;
      id_buf_q  <= '0;
      id_cnt_q  <= '0;
      id_ovf_q  <= 1'b0;
    end else begin
      st_q      <= st_d;
      acc_q     <= acc_d;
      num_ovf_q <= num_ovf_d;
      id_buf_q  <= id_buf_d;
      id_cnt_q  <= id_cnt_d;
      id_ovf_q  <= id_ovf_d;
    end
  end

  a_end_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && is_end |=> st_q == ST_IDLE)
    else $error("end-of-input beat left a token pending");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.count == 2'd2 |->
      (res_o.first.token_kind == TK_NUMBER || res_o.first.token_kind == TK_IDENT))
    else $error("two results without a pending token first");

  a_ident_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDENT |-> id_cnt_q != '0 && id_cnt_q <= IdentLenW'(MaxIdentChars))
    else $error("identifier length out of range");

endmodule

/* sv/elx_outq.sv */
module elx_outq import elx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  elx_pair_t pair_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output lex_out_t  data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  lex_out_t          mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n  = push_i ? pair_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  // a beat may bring two results, so keep two slots free
  assign room_o  = (cnt_q <= CntW'(QDepth - 2));

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_n);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= pair_i.first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= pair_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != 2'd0 |-> cnt_q <= CntW'(QDepth - 2))
    else $error("results pushed without room");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue count beyond depth");

  a_run_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !data_o.last_of_run |-> cnt_q >= CntW'(2))
    else $error("head is mid-run but its follower is missing");

endmodule

/* sv/expression_lexer_core.sv */
// channel | dir | handshake                | payload
// --------+-----+--------------------------+--------------------------
// in      | in  | in_valid_i / in_ready_o  | in_data_i  (lex_in_t)
// out     | out | out_valid_o / out_ready_i| out_data_o (lex_out_t)
//
// One input beat is taken per cycle while in_ready_o is high; its results are queued.
// A beat that closes a pending token and is itself a token gives two results, which
// leave one a cycle while out_ready_i is high; the four-entry result queue sets how far
// input runs ahead. in_ready_o drops while fewer than two queue slots are free.
// Reset clears the scanner state to idle and empties the queue.
module expression_lexer_core import elx_pkg::*; #(
  parameter int unsigned MaxIdentChars = MaxIdentCharsDef,
  parameter int unsigned NumberBits    = NumberBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lex_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lex_out_t out_data_o
);

  logic      take;
  elx_pair_t pair;

  assign take = in_valid_i && in_ready_o;

  elx_scan #(
    .MaxIdentChars (MaxIdentChars),
    .NumberBits    (NumberBits)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .in_i   (in_data_i),
    .res_o  (pair)
  );

  elx_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .pair_i  (pair),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule
